@@ src/mrle_pkg.sv @@
// ============================================================================
// mrle_pkg
// Shared types and constants of the mixed run-length scanline decoder.
// ============================================================================
package mrle_pkg;

    localparam int COL_W  = 16;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_COLUMNS     = 2'd0;
    localparam logic [IDX_W-1:0] REG_LAYOUT      = 2'd1;
    localparam logic [IDX_W-1:0] REG_RGB_CODED   = 2'd2;
    localparam logic [IDX_W-1:0] REG_ALPHA_CODED = 2'd3;

    // pixel layouts
    localparam logic [1:0] LAYOUT_RGB   = 2'd0;
    localparam logic [1:0] LAYOUT_RGBA  = 2'd1;
    localparam logic [1:0] LAYOUT_SPLIT = 2'd2;

    // result targets
    localparam logic [1:0] TGT_COLOR = 2'd0;
    localparam logic [1:0] TGT_ALPHA = 2'd1;
    localparam logic [1:0] TGT_BOTH  = 2'd2;

    localparam logic [BYTE_W-1:0] COUNT_ESCAPE = 8'd128;
    localparam logic [COL_W-1:0]  REP_BIAS     = 16'd127;

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_HIGH  = 3'd1,
        PH_LOW   = 3'd2,
        PH_LIT   = 3'd3,
        PH_REP   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [COL_W-1:0] columns;
        logic [1:0]       pixel_layout;
        logic             rgb_compressed;
        logic             alpha_compressed;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [COL_W-1:0]  pixel_count;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [1:0]        target;
        logic              row_end;
        logic              overrun;
    } res_t;

endpackage

@@ src/mrle_cfg_regs.sv @@
// ============================================================================
// mrle_cfg_regs
// Configuration register file: row width, pixel layout, pass coding flags.
// ============================================================================
module mrle_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mrle_pkg::IDX_W-1:0]    cfg_index,
    input  logic [mrle_pkg::CFG_W-1:0]    cfg_wdata,
    output mrle_pkg::cfg_t                cfg
);
    import mrle_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COLUMNS:     cfg_next.columns          = cfg_wdata[COL_W-1:0];
                REG_LAYOUT:      cfg_next.pixel_layout     = cfg_wdata[1:0];
                REG_RGB_CODED:   cfg_next.rgb_compressed   = cfg_wdata[0];
                REG_ALPHA_CODED: cfg_next.alpha_compressed = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.columns          <= 16'd1;
            cfg_reg.pixel_layout     <= LAYOUT_RGB;
            cfg_reg.rgb_compressed   <= 1'b1;
            cfg_reg.alpha_compressed <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/mrle_core.sv @@
// ============================================================================
// mrle_core
// Per-byte decode step: phase tracking, run checks, pixel assembly and
// column bookkeeping. One byte is consumed per enabled cycle.
// ============================================================================
module mrle_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mrle_pkg::cfg_t                cfg,
    input  logic                          step_en,
    input  logic [mrle_pkg::BYTE_W-1:0]   data_byte,
    output logic                          res_valid,
    output mrle_pkg::res_t                res
);
    import mrle_pkg::*;

    phase_t             phase_reg,      phase_next;
    logic [COL_W-1:0]   cur_col_reg,    cur_col_next;
    logic [BYTE_W-1:0]  lit_left_reg,   lit_left_next;
    logic [COL_W-1:0]   rep_cnt_reg,    rep_cnt_next;
    logic [1:0]         comp_idx_reg,   comp_idx_next;
    logic [23:0]        held_reg,       held_next;
    logic               alpha_pass_reg, alpha_pass_next;
    logic               halted_reg,     halted_next;

    logic               alpha_act;
    logic               coded;
    logic [1:0]         pass_tgt;
    logic [2:0]         pix_size;
    logic [COL_W-1:0]   chk_len;
    logic [COL_W:0]     chk_sum;
    logic               run_over;

    logic               pixel;
    logic               raw_start;
    logic               lit_mode;
    logic [1:0]         ci_eff;
    logic [BYTE_W-1:0]  lit_eff;
    logic [BYTE_W-1:0]  lit_dec;
    logic [COL_W-1:0]   run_len;
    logic [COL_W:0]     end_sum;

    assign alpha_act = alpha_pass_reg && (cfg.pixel_layout == LAYOUT_SPLIT);
    assign coded     = alpha_act ? cfg.alpha_compressed : cfg.rgb_compressed;
    assign pass_tgt  = alpha_act ? TGT_ALPHA :
                       (cfg.pixel_layout == LAYOUT_RGBA) ? TGT_BOTH : TGT_COLOR;
    assign pix_size  = alpha_act ? 3'd1 :
                       (cfg.pixel_layout == LAYOUT_RGBA) ? 3'd4 : 3'd3;

    // length of the run whose bound is checked this byte
    always_comb begin
        case (phase_reg)
            PH_LOW: chk_len = {rep_cnt_reg[15:8], data_byte};
            default: begin
                if (!coded) begin
                    chk_len = 16'd1;
                end else if (data_byte < COUNT_ESCAPE) begin
                    chk_len = {8'h00, data_byte} + 16'd1;
                end else begin
                    chk_len = {8'h00, data_byte} - REP_BIAS;
                end
            end
        endcase
    end

    assign chk_sum  = {1'b0, cur_col_reg} + {1'b0, chk_len};
    assign run_over = chk_sum > {1'b0, cfg.columns};

    always_comb begin
        phase_next      = phase_reg;
        cur_col_next    = cur_col_reg;
        lit_left_next   = lit_left_reg;
        rep_cnt_next    = rep_cnt_reg;
        comp_idx_next   = comp_idx_reg;
        held_next       = held_reg;
        alpha_pass_next = alpha_pass_reg;
        halted_next     = halted_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.target      = pass_tgt;
        pixel           = 1'b0;
        raw_start       = 1'b0;
        lit_mode        = 1'b0;
        ci_eff          = comp_idx_reg;
        lit_eff         = lit_left_reg;
        lit_dec         = '0;
        run_len         = '0;
        end_sum         = '0;

        if (step_en && !halted_reg) begin
            unique case (phase_reg)
                PH_HIGH: begin
                    rep_cnt_next = {data_byte, 8'h00};
                    phase_next   = PH_LOW;
                end
                PH_LOW: begin
                    rep_cnt_next = chk_len;
                    if (run_over) begin
                        res_valid   = 1'b1;
                        res.column  = cur_col_reg;
                        res.overrun = 1'b1;
                        halted_next = 1'b1;
                    end else begin
                        phase_next    = PH_REP;
                        comp_idx_next = '0;
                    end
                end
                PH_LIT, PH_REP: begin
                    pixel = 1'b1;
                end
                default: begin
                    phase_next = PH_COUNT;
                    if (coded && data_byte == COUNT_ESCAPE) begin
                        phase_next    = PH_HIGH;
                        comp_idx_next = '0;
                    end else if (run_over) begin
                        res_valid   = 1'b1;
                        res.column  = cur_col_reg;
                        res.overrun = 1'b1;
                        halted_next = 1'b1;
                    end else if (coded) begin
                        comp_idx_next = '0;
                        if (data_byte < COUNT_ESCAPE) begin
                            lit_left_next = chk_len[BYTE_W-1:0];
                            phase_next    = PH_LIT;
                        end else begin
                            rep_cnt_next = chk_len;
                            phase_next   = PH_REP;
                        end
                    end else begin
                        raw_start     = 1'b1;
                        pixel         = 1'b1;
                        lit_left_next = 8'd1;
                        phase_next    = PH_LIT;
                    end
                end
            endcase

            if (pixel) begin
                ci_eff   = raw_start ? 2'd0 : comp_idx_reg;
                lit_eff  = raw_start ? 8'd1 : lit_left_reg;
                lit_mode = raw_start || (phase_reg == PH_LIT);
                if (({1'b0, ci_eff} + 3'd1) < pix_size) begin
                    case (ci_eff)
                        2'd0:    held_next[23:16] = data_byte;
                        2'd1:    held_next[15:8]  = data_byte;
                        2'd2:    held_next[7:0]   = data_byte;
                        default: ;
                    endcase
                    comp_idx_next = ci_eff + 2'd1;
                end else begin
                    comp_idx_next = '0;
                    if (lit_mode) begin
                        run_len       = 16'd1;
                        lit_dec       = lit_eff - 8'd1;
                        lit_left_next = lit_dec;
                        phase_next    = (lit_dec == '0) ? PH_COUNT : PH_LIT;
                    end else begin
                        run_len    = rep_cnt_reg;
                        phase_next = PH_COUNT;
                    end
                    if (run_len != '0) begin
                        end_sum         = {1'b0, cur_col_reg} + {1'b0, run_len};
                        cur_col_next    = end_sum[COL_W-1:0];
                        res_valid       = 1'b1;
                        res.column      = cur_col_reg;
                        res.pixel_count = run_len;
                        if (alpha_act) begin
                            res.alpha = data_byte;
                        end else if (pix_size == 3'd4) begin
                            res.red   = held_reg[23:16];
                            res.green = held_reg[15:8];
                            res.blue  = held_reg[7:0];
                            res.alpha = data_byte;
                        end else begin
                            res.red   = held_reg[23:16];
                            res.green = held_reg[15:8];
                            res.blue  = data_byte;
                        end
                        if (end_sum == {1'b0, cfg.columns}) begin
                            cur_col_next  = '0;
                            lit_left_next = '0;
                            phase_next    = PH_COUNT;
                            if (cfg.pixel_layout == LAYOUT_SPLIT && !alpha_pass_reg) begin
                                alpha_pass_next = 1'b1;
                            end else begin
                                alpha_pass_next = 1'b0;
                                res.row_end     = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_COUNT;
            cur_col_reg    <= '0;
            lit_left_reg   <= '0;
            rep_cnt_reg    <= '0;
            comp_idx_reg   <= '0;
            held_reg       <= '0;
            alpha_pass_reg <= 1'b0;
            halted_reg     <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            cur_col_reg    <= cur_col_next;
            lit_left_reg   <= lit_left_next;
            rep_cnt_reg    <= rep_cnt_next;
            comp_idx_reg   <= comp_idx_next;
            held_reg       <= held_next;
            alpha_pass_reg <= alpha_pass_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

@@ src/mixed_rle_scanline_decoder.sv @@
// ============================================================================
// mixed_rle_scanline_decoder
// Byte-stream decoder for RGB / RGBA / split-alpha scanlines, raw or mixed
// run-length coded, reporting one run word per decoded pixel run.
// ============================================================================
// Usage:
//   s_ channel: one encoded byte per word. m_ channel: one run word
//   (column, length, components, target, row_end, overrun).
//   An accepted byte waits in the input register and is decoded from there;
//   its run word, if any, is then registered in the output register.
//   One byte per cycle while no held word stalls the decode step, which is
//   combinational between the input register and the output register.
//   Count bytes, escape bytes, partial pixels and zero-length runs produce
//   no word, unless a run length overruns the row (overrun word).
//   When m_ready is low with a word held, the input register still takes
//   one more byte; further bytes wait until the word is taken.
//   An overrun word halts decoding; bytes are then accepted and dropped
//   until reset.
//   Reset (aresetn low, synchronous) empties both registers and returns
//   the configuration and decode state to their defaults.
//   Configuration writes (cfg_wr_en) take effect at once; issue them only
//   while the block is idle.
// ============================================================================
module mixed_rle_scanline_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mrle_pkg::IDX_W-1:0]    cfg_index,
    input  logic [mrle_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mrle_pkg::BYTE_W-1:0]   s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mrle_pkg::COL_W-1:0]    m_column,
    output logic [mrle_pkg::COL_W-1:0]    m_pixel_count,
    output logic [mrle_pkg::BYTE_W-1:0]   m_red,
    output logic [mrle_pkg::BYTE_W-1:0]   m_green,
    output logic [mrle_pkg::BYTE_W-1:0]   m_blue,
    output logic [mrle_pkg::BYTE_W-1:0]   m_alpha,
    output logic [1:0]                    m_target,
    output logic                          m_row_end,
    output logic                          m_overrun
);
    import mrle_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg,  in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg,   in_byte_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg,   out_res_next;
    logic              advance;
    logic              res_valid;
    res_t              res;

    mrle_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mrle_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step_en   (advance),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_data_byte;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        out_res_reg <= out_res_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_column      = out_res_reg.column;
    assign m_pixel_count = out_res_reg.pixel_count;
    assign m_red         = out_res_reg.red;
    assign m_green       = out_res_reg.green;
    assign m_blue        = out_res_reg.blue;
    assign m_alpha       = out_res_reg.alpha;
    assign m_target      = out_res_reg.target;
    assign m_row_end     = out_res_reg.row_end;
    assign m_overrun     = out_res_reg.overrun;

endmodule

@@ src/mrle_checker.sv @@
// ============================================================================
// mrle_checker
// Port-level checks on the decoder's run words, bound to the top level.
// ============================================================================
module mrle_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mrle_pkg::COL_W-1:0]    m_column,
    input logic [mrle_pkg::COL_W-1:0]    m_pixel_count,
    input logic                          m_row_end,
    input logic                          m_overrun
);
    import mrle_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column) && $stable(m_pixel_count))
        else $error("run word changed while stalled");

    // error words carry no length and never close a row
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overrun |-> m_pixel_count == '0 && !m_row_end)
        else $error("malformed overrun word");

    // normal runs are never empty
    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_overrun |-> m_pixel_count != '0)
        else $error("empty run word");

    // halted after an overrun
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_overrun |=> !m_valid)
        else $error("word after overrun");

endmodule

bind mixed_rle_scanline_decoder mrle_checker u_mrle_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_column      (m_column),
    .m_pixel_count (m_pixel_count),
    .m_row_end     (m_row_end),
    .m_overrun     (m_overrun)
);
